/* hdl/rabm_pkg.sv */
// Shared types and constants for the req/ack bus master.
package rabm_pkg;

    localparam int WORD_W  = 32;
    localparam int LIMIT_W = 8;

    localparam logic [LIMIT_W-1:0] STROBE_LIMIT_RST = LIMIT_W'(16);

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_TRANSFER = 2'd1,
        PH_FINAL    = 2'd2
    } phase_t;

    typedef struct packed {
        logic              complete;
        logic [WORD_W-1:0] read_data;
        logic              bus_error;
        logic [WORD_W-1:0] bus_address;
        logic              bus_rw;
        logic              bus_req;
        logic [WORD_W-1:0] bus_data_out;
    } result_t;

endpackage

/* hdl/rabm_out_buf.sv */
// Result register with a skid stage, so a new transaction is taken while one waits.
module rabm_out_buf import rabm_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_acc;
    logic    out_load;

    assign in_ready  = !skid_valid_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_acc;
                end
            end else if (in_acc) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_acc) begin
                out_data_reg <= in_data;
            end
        end else if (in_acc) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

/* hdl/req_ack_bus_master.sv */
// Top level: four-phase req/ack bus master with strobe timeout.
//
//  channel  | dir | handshake             | contents
//  ---------+-----+-----------------------+------------------------------------------
//  cfg      | in  | cfg_valid / cfg_ready | cfg_data: strobe limit
//  s_       | in  | s_valid / s_ready     | mode, address, write data, ack, bus data
//  m_       | out | m_valid / m_ready     | complete, read data, error, bus drive
//
// One transaction per clock while s_ready is high: the controller state advances at the
// accepting edge and the result is registered in the same cycle, in the skid stage if stalled.
// A skid stage behind the result register keeps s_ready high while one result waits.
// s_ready falls only when both result stages are full.
// Reset (aresetn low, synchronous) clears all control state; strobe limit returns to 16.
module req_ack_bus_master import rabm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [WORD_W-1:0]  s_address,
    input  logic [WORD_W-1:0]  s_write_data,
    input  logic               s_ack_in,
    input  logic [WORD_W-1:0]  s_bus_data_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_complete,
    output logic [WORD_W-1:0]  m_read_data,
    output logic               m_bus_error,
    output logic [WORD_W-1:0]  m_bus_address,
    output logic               m_bus_rw,
    output logic               m_bus_req,
    output logic [WORD_W-1:0]  m_bus_data_out
);

    logic [LIMIT_W-1:0] strobe_limit_reg;

    phase_t             phase_reg,     phase_next;
    logic [LIMIT_W-1:0] countdown_reg, countdown_next;
    logic [WORD_W-1:0]  captured_reg,  captured_next;
    logic [WORD_W-1:0]  address_reg,   address_next;
    logic [WORD_W-1:0]  data_reg,      data_next;
    logic               dir_reg,       dir_next;
    logic               req_reg,       req_next;
    logic               ack_reg,       ack_next;

    result_t res;
    result_t m_res;
    logic    s_acc;
    logic    active;
    logic    is_write;
    logic    complete;
    logic    bus_error;
    logic [WORD_W-1:0]  rdata;
    logic [LIMIT_W-1:0] cd_dec;

    assign cfg_ready = 1'b1;
    assign s_acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strobe_limit_reg <= STROBE_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            strobe_limit_reg <= cfg_data;
        end
    end

    always_comb begin
        active         = (s_mode == MODE_READ) || (s_mode == MODE_WRITE);
        is_write       = (s_mode == MODE_WRITE);
        cd_dec         = countdown_reg - LIMIT_W'(1);
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        captured_next  = captured_reg;
        address_next   = address_reg;
        data_next      = data_reg;
        dir_next       = dir_reg;
        req_next       = req_reg;
        complete       = 1'b0;
        bus_error      = 1'b0;
        rdata          = '0;
        if (active) begin
            case (phase_reg)
                PH_TRANSFER: begin
                    if (req_reg && ack_reg) begin
                        if (!is_write) begin
                            captured_next = data_reg;
                        end
                        req_next   = 1'b0;
                        phase_next = PH_FINAL;
                    end else begin
                        countdown_next = cd_dec;
                        if (cd_dec == '0) begin
                            phase_next = PH_FINAL;
                        end
                    end
                end
                PH_FINAL: begin
                    if ((!req_reg && !ack_reg) || countdown_reg == '0) begin
                        phase_next     = PH_IDLE;
                        complete       = 1'b1;
                        countdown_next = '0;
                        if (!is_write) begin
                            rdata         = captured_reg;
                            captured_next = '0;
                        end
                    end
                end
                default: begin
                    if (!req_reg && !ack_reg) begin
                        countdown_next = strobe_limit_reg;
                        address_next   = s_address;
                        if (is_write) begin
                            data_next = s_write_data;
                        end
                        dir_next   = is_write;
                        req_next   = 1'b1;
                        phase_next = PH_TRANSFER;
                    end else begin
                        bus_error  = 1'b1;
                        req_next   = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
        // bus sampled for the next transaction
        ack_next = s_ack_in;
        if (!dir_next) begin
            data_next = s_bus_data_in;
        end

        res.complete     = complete;
        res.read_data    = rdata;
        res.bus_error    = bus_error;
        res.bus_address  = address_next;
        res.bus_rw       = dir_next;
        res.bus_req      = req_next;
        res.bus_data_out = dir_next ? data_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            countdown_reg <= '0;
            captured_reg  <= '0;
            address_reg   <= '0;
            data_reg      <= '0;
            dir_reg       <= 1'b0;
            req_reg       <= 1'b0;
            ack_reg       <= 1'b0;
        end else if (s_acc) begin
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            captured_reg  <= captured_next;
            address_reg   <= address_next;
            data_reg      <= data_next;
            dir_reg       <= dir_next;
            req_reg       <= req_next;
            ack_reg       <= ack_next;
        end
    end

    rabm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_res)
    );

    assign m_complete     = m_res.complete;
    assign m_read_data    = m_res.read_data;
    assign m_bus_error    = m_res.bus_error;
    assign m_bus_address  = m_res.bus_address;
    assign m_bus_rw       = m_res.bus_rw;
    assign m_bus_req      = m_res.bus_req;
    assign m_bus_data_out = m_res.bus_data_out;

endmodule

/* hdl/rabm_checker.sv */
// Port-level assertions for the req/ack bus master, bound to the top level.
module rabm_checker import rabm_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_complete,
    input logic [WORD_W-1:0]  m_read_data,
    input logic               m_bus_error,
    input logic               m_bus_rw,
    input logic               m_bus_req,
    input logic [WORD_W-1:0]  m_bus_data_out
);

    // an error start drops req
    a_err_drops_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bus_error |-> !m_bus_req)
        else $error("bus error with req high");

    a_err_not_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bus_error |-> !m_complete)
        else $error("bus error and completion together");

    a_rdata_on_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_complete |-> m_read_data == '0)
        else $error("read data without completion");

    a_wdata_on_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bus_rw |-> m_bus_data_out == '0)
        else $error("write data driven in read direction");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_complete))
        else $error("stalled result changed");

endmodule

bind req_ack_bus_master rabm_checker u_rabm_checker (.*);
